// ===== rtl/tlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpf_pkg
// Shared constants, codes and types of the three-level priority FIFO.
// ----------------------------------------------------------------------------
package tlpf_pkg;

  localparam int ClassDepth = 16;
  localparam int DataWidth  = 32;
  localparam int PrioCount  = 3;

  localparam int AddrW  = (ClassDepth > 1) ? $clog2(ClassDepth) : 1;
  localparam int FillW  = $clog2(ClassDepth + 1);
  localparam int TotW   = $clog2(PrioCount * ClassDepth + 1);

  localparam int ModeW     = 2;
  localparam int PrioW     = 3;
  localparam int PosW      = 6;
  localparam int StatusW   = 3;
  localparam int ClassW    = 2;
  localparam int CountW    = 5;
  localparam int TotalW    = 6;
  localparam int PortDataW = 32;

  localparam int CmpW = (TotW > PosW) ? TotW : PosW;

  localparam logic [ModeW-1:0] ModePush  = 2'd0;
  localparam logic [ModeW-1:0] ModePop   = 2'd1;
  localparam logic [ModeW-1:0] ModeFront = 2'd2;
  localparam logic [ModeW-1:0] ModeIndex = 2'd3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StBadPrio  = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StBadIndex = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;

  localparam logic [ClassW-1:0] ClassNone = 2'd0;
  localparam logic [ClassW-1:0] ClassHigh = 2'd1;
  localparam logic [ClassW-1:0] ClassMed  = 2'd2;
  localparam logic [ClassW-1:0] ClassLow  = 2'd3;

  localparam logic [ClassW-1:0] IdxHigh = 2'd0;
  localparam logic [ClassW-1:0] IdxMed  = 2'd1;
  localparam logic [ClassW-1:0] IdxLow  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_hold;
  } sts_t;

endpackage

// ===== rtl/three_level_priority_fifo_unit.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_fifo_unit
// Strict priority queue of data words in three FIFO classes.
// ----------------------------------------------------------------------------
// Each operation (push, pop, read front, read at position) passes in order
// from the input transfer through capture, class store access with pointer
// update, and loading of the result into the output register. The store's
// registered read port keeps the access and the load apart. The load waits
// while a stalled result still sits in the output register. A new operation
// is accepted as soon as the previous result is loaded, even while that
// result still waits for its transfer, but not before.
module three_level_priority_fifo_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tlpf_pkg::ModeW-1:0]     mode_i,
  input  logic [tlpf_pkg::PrioW-1:0]     prio_class_i,
  input  logic [tlpf_pkg::PortDataW-1:0] push_data_i,
  input  logic [tlpf_pkg::PosW-1:0]      position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tlpf_pkg::StatusW-1:0]   status_o,
  output logic [tlpf_pkg::PortDataW-1:0] read_data_o,
  output logic [tlpf_pkg::ClassW-1:0]    read_class_o,
  output logic [tlpf_pkg::TotalW-1:0]    total_count_o,
  output logic [tlpf_pkg::CountW-1:0]    high_count_o,
  output logic [tlpf_pkg::CountW-1:0]    medium_count_o,
  output logic [tlpf_pkg::CountW-1:0]    low_count_o
);

  tlpf_pkg::cmd_t cmd;
  tlpf_pkg::sts_t sts;

  tlpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlpf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .prio_class_i   (prio_class_i),
    .push_data_i    (push_data_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .read_data_o    (read_data_o),
    .read_class_o   (read_class_o),
    .total_count_o  (total_count_o),
    .high_count_o   (high_count_o),
    .medium_count_o (medium_count_o),
    .low_count_o    (low_count_o)
  );

endmodule

// ===== rtl/tlpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpf_ctrl
// Sequencer: takes an operation, runs it through the datapath, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tlpf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tlpf_pkg::sts_t sts_i,
  output tlpf_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StResp = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StResp;
      end
      StResp: begin
        if (!sts_i.out_hold) begin
          cmd_o.load = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tlpf_datapath.sv =====
// ----------------------------------------------------------------------------
// tlpf_datapath
// Class stores, head pointers, fill counts, position decode and output
// register of the three-level priority FIFO.
// ----------------------------------------------------------------------------
module tlpf_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tlpf_pkg::cmd_t                   cmd_i,
  output tlpf_pkg::sts_t                   sts_o,
  input  logic [tlpf_pkg::ModeW-1:0]       mode_i,
  input  logic [tlpf_pkg::PrioW-1:0]       prio_class_i,
  input  logic [tlpf_pkg::PortDataW-1:0]   push_data_i,
  input  logic [tlpf_pkg::PosW-1:0]        position_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tlpf_pkg::StatusW-1:0]     status_o,
  output logic [tlpf_pkg::PortDataW-1:0]   read_data_o,
  output logic [tlpf_pkg::ClassW-1:0]      read_class_o,
  output logic [tlpf_pkg::TotalW-1:0]      total_count_o,
  output logic [tlpf_pkg::CountW-1:0]      high_count_o,
  output logic [tlpf_pkg::CountW-1:0]      medium_count_o,
  output logic [tlpf_pkg::CountW-1:0]      low_count_o
);

  // operation register
  logic [tlpf_pkg::ModeW-1:0]     mode_q;
  logic [tlpf_pkg::PrioW-1:0]     prio_q;
  logic [tlpf_pkg::DataWidth-1:0] data_q;
  logic [tlpf_pkg::PosW-1:0]      pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      prio_q <= prio_class_i;
      data_q <= tlpf_pkg::DataWidth'(push_data_i);
      pos_q  <= position_i;
    end
  end

  // per-class pointers and counts
  logic [tlpf_pkg::AddrW-1:0] head_q [tlpf_pkg::PrioCount];
  logic [tlpf_pkg::FillW-1:0] fill_q [tlpf_pkg::PrioCount];

  // decode
  logic [tlpf_pkg::CmpW-1:0]    pos_w, hf_w, hm_w, tot_w;
  logic [tlpf_pkg::StatusW-1:0] ex_status;
  logic [tlpf_pkg::ClassW-1:0]  ex_class;
  logic [tlpf_pkg::ClassW-1:0]  sel;
  logic [tlpf_pkg::ClassW-1:0]  front;
  logic [tlpf_pkg::AddrW-1:0]   off;
  logic                         do_wr;
  logic                         do_pop;
  logic [tlpf_pkg::AddrW:0]     slot_sum;
  logic [tlpf_pkg::AddrW-1:0]   slot;

  always_comb begin
    pos_w = tlpf_pkg::CmpW'(pos_q);
    hf_w  = tlpf_pkg::CmpW'(fill_q[tlpf_pkg::IdxHigh]);
    hm_w  = hf_w + tlpf_pkg::CmpW'(fill_q[tlpf_pkg::IdxMed]);
    tot_w = hm_w + tlpf_pkg::CmpW'(fill_q[tlpf_pkg::IdxLow]);

    if (fill_q[tlpf_pkg::IdxHigh] != '0) begin
      front = tlpf_pkg::IdxHigh;
    end else if (fill_q[tlpf_pkg::IdxMed] != '0) begin
      front = tlpf_pkg::IdxMed;
    end else begin
      front = tlpf_pkg::IdxLow;
    end

    ex_status = tlpf_pkg::StOk;
    ex_class  = tlpf_pkg::ClassNone;
    sel       = tlpf_pkg::IdxHigh;
    off       = '0;
    do_wr     = 1'b0;
    do_pop    = 1'b0;

    case (mode_q)
      tlpf_pkg::ModePush: begin
        if (prio_q < tlpf_pkg::PrioW'(tlpf_pkg::ClassHigh) ||
            prio_q > tlpf_pkg::PrioW'(tlpf_pkg::PrioCount)) begin
          ex_status = tlpf_pkg::StBadPrio;
        end else begin
          sel = tlpf_pkg::ClassW'(prio_q) - 2'd1;
          if (fill_q[sel] == tlpf_pkg::FillW'(tlpf_pkg::ClassDepth)) begin
            ex_status = tlpf_pkg::StFull;
          end else begin
            off   = tlpf_pkg::AddrW'(fill_q[sel]);
            do_wr = 1'b1;
          end
        end
      end
      tlpf_pkg::ModePop, tlpf_pkg::ModeFront: begin
        if (tot_w == '0) begin
          ex_status = tlpf_pkg::StEmpty;
        end else begin
          sel      = front;
          ex_class = front + 2'd1;
          do_pop   = (mode_q == tlpf_pkg::ModePop);
        end
      end
      default: begin
        if (pos_w >= tot_w) begin
          ex_status = tlpf_pkg::StBadIndex;
        end else if (pos_w < hf_w) begin
          sel      = tlpf_pkg::IdxHigh;
          ex_class = tlpf_pkg::ClassHigh;
          off      = tlpf_pkg::AddrW'(pos_w);
        end else if (pos_w < hm_w) begin
          sel      = tlpf_pkg::IdxMed;
          ex_class = tlpf_pkg::ClassMed;
          off      = tlpf_pkg::AddrW'(pos_w - hf_w);
        end else begin
          sel      = tlpf_pkg::IdxLow;
          ex_class = tlpf_pkg::ClassLow;
          off      = tlpf_pkg::AddrW'(pos_w - hm_w);
        end
      end
    endcase

    slot_sum = (tlpf_pkg::AddrW + 1)'(head_q[sel]) + (tlpf_pkg::AddrW + 1)'(off);
    if (slot_sum >= (tlpf_pkg::AddrW + 1)'(tlpf_pkg::ClassDepth)) begin
      slot = tlpf_pkg::AddrW'(slot_sum - (tlpf_pkg::AddrW + 1)'(tlpf_pkg::ClassDepth));
    end else begin
      slot = tlpf_pkg::AddrW'(slot_sum);
    end
  end

  // class stores and pointers
  logic [tlpf_pkg::DataWidth-1:0] rdata_q [tlpf_pkg::PrioCount];

  for (genvar c = 0; c < tlpf_pkg::PrioCount; c++) begin : g_class
    logic [tlpf_pkg::DataWidth-1:0] mem [tlpf_pkg::ClassDepth];
    logic                           hit;

    assign hit = (sel == tlpf_pkg::ClassW'(c));

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec && do_wr && hit) begin
        mem[slot] <= data_q;
      end
      if (cmd_i.exec) begin
        rdata_q[c] <= mem[slot];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end else if (cmd_i.exec && hit) begin
        if (do_wr) begin
          fill_q[c] <= fill_q[c] + 1'b1;
        end else if (do_pop) begin
          fill_q[c] <= fill_q[c] - 1'b1;
          if (head_q[c] == tlpf_pkg::AddrW'(tlpf_pkg::ClassDepth - 1)) begin
            head_q[c] <= '0;
          end else begin
            head_q[c] <= head_q[c] + 1'b1;
          end
        end
      end
    end
  end

  // pending result
  logic [tlpf_pkg::StatusW-1:0] res_status_q;
  logic [tlpf_pkg::ClassW-1:0]  res_class_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= ex_status;
      res_class_q  <= ex_class;
    end
  end

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [tlpf_pkg::StatusW-1:0]   status_q;
  logic [tlpf_pkg::PortDataW-1:0] read_data_q;
  logic [tlpf_pkg::ClassW-1:0]    read_class_q;
  logic [tlpf_pkg::TotalW-1:0]    total_q;
  logic [tlpf_pkg::CountW-1:0]    high_q, med_q, low_q;
  logic [tlpf_pkg::PortDataW-1:0] res_data;

  always_comb begin
    if (res_class_q == tlpf_pkg::ClassNone) begin
      res_data = '0;
    end else begin
      res_data = tlpf_pkg::PortDataW'(rdata_q[res_class_q - 2'd1]);
    end

    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q     <= res_status_q;
      read_data_q  <= res_data;
      read_class_q <= res_class_q;
      total_q      <= tlpf_pkg::TotalW'(tot_w);
      high_q       <= tlpf_pkg::CountW'(fill_q[tlpf_pkg::IdxHigh]);
      med_q        <= tlpf_pkg::CountW'(fill_q[tlpf_pkg::IdxMed]);
      low_q        <= tlpf_pkg::CountW'(fill_q[tlpf_pkg::IdxLow]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_hold = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign read_data_o    = read_data_q;
  assign read_class_o   = read_class_q;
  assign total_count_o  = total_q;
  assign high_count_o   = high_q;
  assign medium_count_o = med_q;
  assign low_count_o    = low_q;

endmodule

// ===== rtl/tlpf_checker.sv =====
// ----------------------------------------------------------------------------
// tlpf_checker
// Port-level checks of the three-level priority FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module tlpf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [tlpf_pkg::StatusW-1:0]   status_o,
  input  logic [tlpf_pkg::PortDataW-1:0] read_data_o,
  input  logic [tlpf_pkg::ClassW-1:0]    read_class_o,
  input  logic [tlpf_pkg::TotalW-1:0]    total_count_o,
  input  logic [tlpf_pkg::CountW-1:0]    high_count_o,
  input  logic [tlpf_pkg::CountW-1:0]    medium_count_o,
  input  logic [tlpf_pkg::CountW-1:0]    low_count_o
);

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_count_o == (tlpf_pkg::TotalW'(high_count_o) +
                                      tlpf_pkg::TotalW'(medium_count_o) +
                                      tlpf_pkg::TotalW'(low_count_o)))
    else $error("total count differs from class counts");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tlpf_pkg::StOk |->
      read_class_o == tlpf_pkg::ClassNone && read_data_o == '0)
    else $error("error result carries data");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tlpf_pkg::StEmpty |-> total_count_o == '0)
    else $error("empty status with items held");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(read_data_o) &&
      $stable(read_class_o) && $stable(total_count_o))
    else $error("stalled result changed");

endmodule

bind three_level_priority_fifo_unit tlpf_checker u_tlpf_checker (.*);

// ===== dv/three_level_priority_fifo_unit_tb.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_fifo_unit_tb
// Self-checking bench for the three-level priority FIFO.
// A queue of pre-built operations (directed corner cases, then phases of
// fill, drain, mixed and single-class traffic) feeds a clocked driver. A
// priority-queue predictor runs on each input transfer, and a clocked
// monitor compares every output transfer field by field. Both sides idle at
// random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module three_level_priority_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumOps    = 1950;
  localparam int HoldStart = 400;
  localparam int HoldLen   = 250;
  localparam int IdleLimit = 2000;

  typedef struct {
    logic [tlpf_pkg::ModeW-1:0]     mode;
    logic [tlpf_pkg::PrioW-1:0]     prio;
    logic [tlpf_pkg::PortDataW-1:0] data;
    logic [tlpf_pkg::PosW-1:0]      pos;
    int                             gap;
  } op_t;

  typedef struct packed {
    logic [tlpf_pkg::StatusW-1:0]   status;
    logic [tlpf_pkg::PortDataW-1:0] data;
    logic [tlpf_pkg::ClassW-1:0]    cls;
    logic [tlpf_pkg::TotalW-1:0]    total;
    logic [tlpf_pkg::CountW-1:0]    high;
    logic [tlpf_pkg::CountW-1:0]    med;
    logic [tlpf_pkg::CountW-1:0]    low;
  } result_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           out_stall  = 1'b0;
  logic [tlpf_pkg::ModeW-1:0]     mode       = '0;
  logic [tlpf_pkg::PrioW-1:0]     prio_class = '0;
  logic [tlpf_pkg::PortDataW-1:0] push_data  = '0;
  logic [tlpf_pkg::PosW-1:0]      position   = '0;
  logic                           hold_rx    = 1'b0;

  logic                           in_stall_o;
  logic                           out_valid_o;
  logic [tlpf_pkg::StatusW-1:0]   status_o;
  logic [tlpf_pkg::PortDataW-1:0] read_data_o;
  logic [tlpf_pkg::ClassW-1:0]    read_class_o;
  logic [tlpf_pkg::TotalW-1:0]    total_count_o;
  logic [tlpf_pkg::CountW-1:0]    high_count_o;
  logic [tlpf_pkg::CountW-1:0]    medium_count_o;
  logic [tlpf_pkg::CountW-1:0]    low_count_o;

  op_t     pending_ops[$];
  result_t expected_q[$];
  op_t     cur_op;

  // predictor state, one FIFO per class, index 0 is high
  logic [tlpf_pkg::PortDataW-1:0] slot_mem[tlpf_pkg::PrioCount][tlpf_pkg::ClassDepth];
  int rd_ptr[tlpf_pkg::PrioCount] = '{default: 0};
  int held[tlpf_pkg::PrioCount]   = '{default: 0};
  int gen_held[tlpf_pkg::PrioCount] = '{default: 0};
  logic [tlpf_pkg::ClassW-1:0] class_code[tlpf_pkg::PrioCount] =
    '{tlpf_pkg::ClassHigh, tlpf_pkg::ClassMed, tlpf_pkg::ClassLow};

  int status_hits[5] = '{default: 0};
  int ops_sent    = 0;
  int results_got = 0;
  int err_count   = 0;
  int idle_cycles = 0;
  int wait_left   = 0;
  int stall_left  = 0;
  bit stall_now   = 1'b0;
  bit rx_calm     = 1'b0;
  int roll;

  three_level_priority_fifo_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode),
    .prio_class_i   (prio_class),
    .push_data_i    (push_data),
    .position_i     (position),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .status_o       (status_o),
    .read_data_o    (read_data_o),
    .read_class_o   (read_class_o),
    .total_count_o  (total_count_o),
    .high_count_o   (high_count_o),
    .medium_count_o (medium_count_o),
    .low_count_o    (low_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int class_index(logic [tlpf_pkg::PrioW-1:0] p);
    case (p)
      tlpf_pkg::PrioW'(tlpf_pkg::ClassHigh): return 0;
      tlpf_pkg::PrioW'(tlpf_pkg::ClassMed):  return 1;
      tlpf_pkg::PrioW'(tlpf_pkg::ClassLow):  return 2;
      default:                               return -1;
    endcase
  endfunction

  function automatic result_t apply_op(op_t op);
    result_t r;
    int c;
    int tot;
    int off;
    r   = '0;
    c   = -1;
    tot = held[0] + held[1] + held[2];
    case (op.mode)
      tlpf_pkg::ModePush: begin
        c = class_index(op.prio);
        if (c < 0) begin
          r.status = tlpf_pkg::StBadPrio;
        end else if (held[c] >= tlpf_pkg::ClassDepth) begin
          r.status = tlpf_pkg::StFull;
        end else begin
          slot_mem[c][(rd_ptr[c] + held[c]) % tlpf_pkg::ClassDepth] = op.data;
          held[c]++;
        end
      end
      tlpf_pkg::ModePop, tlpf_pkg::ModeFront: begin
        for (int k = tlpf_pkg::PrioCount - 1; k >= 0; k--) begin
          if (held[k] != 0) c = k;
        end
        if (c < 0) begin
          r.status = tlpf_pkg::StEmpty;
        end else begin
          r.data = slot_mem[c][rd_ptr[c]];
          r.cls  = class_code[c];
          if (op.mode == tlpf_pkg::ModePop) begin
            rd_ptr[c] = (rd_ptr[c] + 1) % tlpf_pkg::ClassDepth;
            held[c]--;
          end
        end
      end
      default: begin
        if (int'(op.pos) >= tot) begin
          r.status = tlpf_pkg::StBadIndex;
        end else begin
          off = int'(op.pos);
          c   = 0;
          while (off >= held[c]) begin
            off -= held[c];
            c++;
          end
          r.data = slot_mem[c][(rd_ptr[c] + off) % tlpf_pkg::ClassDepth];
          r.cls  = class_code[c];
        end
      end
    endcase
    r.total = tlpf_pkg::TotalW'(held[0] + held[1] + held[2]);
    r.high  = tlpf_pkg::CountW'(held[0]);
    r.med   = tlpf_pkg::CountW'(held[1]);
    r.low   = tlpf_pkg::CountW'(held[2]);
    status_hits[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [tlpf_pkg::PortDataW-1:0] got,
                                 logic [tlpf_pkg::PortDataW-1:0] exp_val);
    $display("%0t: result %0d %s mismatch: got 0x%0h, expected 0x%0h",
             $realtime, results_got, what, got, exp_val);
    err_count++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unrequested", got.data, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", tlpf_pkg::PortDataW'(got.status),
                      tlpf_pkg::PortDataW'(want.status));
    if (got.data !== want.data) report_mismatch("read_data", got.data, want.data);
    if (got.cls !== want.cls)
      report_mismatch("read_class", tlpf_pkg::PortDataW'(got.cls),
                      tlpf_pkg::PortDataW'(want.cls));
    if (got.total !== want.total)
      report_mismatch("total_count", tlpf_pkg::PortDataW'(got.total),
                      tlpf_pkg::PortDataW'(want.total));
    if (got.high !== want.high)
      report_mismatch("high_count", tlpf_pkg::PortDataW'(got.high),
                      tlpf_pkg::PortDataW'(want.high));
    if (got.med !== want.med)
      report_mismatch("medium_count", tlpf_pkg::PortDataW'(got.med),
                      tlpf_pkg::PortDataW'(want.med));
    if (got.low !== want.low)
      report_mismatch("low_count", tlpf_pkg::PortDataW'(got.low),
                      tlpf_pkg::PortDataW'(want.low));
  endtask

  // stimulus builder keeps class counts so positions land mostly in range
  task automatic queue_op(logic [tlpf_pkg::ModeW-1:0] m, logic [tlpf_pkg::PrioW-1:0] p,
                          logic [tlpf_pkg::PortDataW-1:0] d,
                          logic [tlpf_pkg::PosW-1:0] pos, int gap);
    op_t op;
    int c;
    op = '{mode: m, prio: p, data: d, pos: pos, gap: gap};
    pending_ops.push_back(op);
    c = -1;
    if (m == tlpf_pkg::ModePush) begin
      c = class_index(p);
      if (c >= 0 && gen_held[c] < tlpf_pkg::ClassDepth) gen_held[c]++;
    end else if (m == tlpf_pkg::ModePop) begin
      for (int k = tlpf_pkg::PrioCount - 1; k >= 0; k--) begin
        if (gen_held[k] != 0) c = k;
      end
      if (c >= 0) gen_held[c]--;
    end
  endtask

  task automatic build_directed();
    queue_op(tlpf_pkg::ModeFront, '0, '0, '0, 0);
    queue_op(tlpf_pkg::ModePop, '0, '0, '0, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd0, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd63, 0);
    queue_op(tlpf_pkg::ModePush, 3'd0, 32'h1234_5678, '0, 0);
    queue_op(tlpf_pkg::ModePush, 3'd4, 32'h1234_5678, '0, 0);
    queue_op(tlpf_pkg::ModePush, 3'd5, 32'h1234_5678, '0, 0);
    queue_op(tlpf_pkg::ModePush, 3'd6, 32'h1234_5678, '0, 0);
    queue_op(tlpf_pkg::ModePush, 3'd7, 32'h1234_5678, '0, 0);
    queue_op(tlpf_pkg::ModePush, tlpf_pkg::PrioW'(tlpf_pkg::ClassLow), 32'h0000_0000, '0, 0);
    queue_op(tlpf_pkg::ModePush, tlpf_pkg::PrioW'(tlpf_pkg::ClassMed), 32'hFFFF_FFFF, '0, 0);
    queue_op(tlpf_pkg::ModePush, tlpf_pkg::PrioW'(tlpf_pkg::ClassHigh), 32'hA5A5_5A5A, '0, 0);
    queue_op(tlpf_pkg::ModePush, tlpf_pkg::PrioW'(tlpf_pkg::ClassHigh), 32'h5A5A_A5A5, '0, 0);
    queue_op(tlpf_pkg::ModeFront, '0, '0, '0, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd0, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd1, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd2, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd3, 0);
    queue_op(tlpf_pkg::ModeIndex, '0, '0, 6'd4, 0);
    for (int k = 0; k < 5; k++) queue_op(tlpf_pkg::ModePop, 3'd7, '1, 6'd63, 0);
  endtask

  task automatic build_random();
    int kind, len, fav, tot, r, gap;
    int push_w, pop_w, front_w;
    logic [tlpf_pkg::ModeW-1:0] m;
    logic [tlpf_pkg::PrioW-1:0] p;
    logic [tlpf_pkg::PosW-1:0]  pos;
    bit tx_calm;
    while (pending_ops.size() < NumOps) begin
      kind    = $urandom_range(0, 3);
      len     = $urandom_range(40, 160);
      fav     = $urandom_range(1, 3);
      tx_calm = ($urandom_range(0, 3) == 0);
      case (kind)
        0:       begin push_w = 65; pop_w = 15; front_w = 10; end
        1:       begin push_w = 20; pop_w = 55; front_w = 10; end
        2:       begin push_w = 35; pop_w = 30; front_w = 15; end
        default: begin push_w = 80; pop_w = 10; front_w = 5;  end
      endcase
      repeat (len) begin
        if (pending_ops.size() >= NumOps) break;
        r = $urandom_range(0, 99);
        if (r < push_w) m = tlpf_pkg::ModePush;
        else if (r < push_w + pop_w) m = tlpf_pkg::ModePop;
        else if (r < push_w + pop_w + front_w) m = tlpf_pkg::ModeFront;
        else m = tlpf_pkg::ModeIndex;
        r = $urandom_range(0, 99);
        if (r < 8) p = tlpf_pkg::PrioW'($urandom_range(0, 7));
        else if (kind == 3 && r < 90) p = tlpf_pkg::PrioW'(fav);
        else p = tlpf_pkg::PrioW'($urandom_range(1, 3));
        tot = gen_held[0] + gen_held[1] + gen_held[2];
        r = $urandom_range(0, 99);
        if (r < 12) pos = tlpf_pkg::PosW'($urandom_range(0, 63));
        else if (r < 20) pos = tlpf_pkg::PosW'(tot);
        else pos = (tot > 0) ? tlpf_pkg::PosW'($urandom_range(0, tot - 1)) : '0;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(6, 30);
        queue_op(m, p, $urandom(), pos, gap);
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_q.push_back(apply_op(cur_op));
        ops_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (wait_left > 0 || pending_ops.size() == 0) begin
          if (wait_left > 0) wait_left--;
          in_valid <= 1'b0;
        end else begin
          cur_op    = pending_ops.pop_front();
          wait_left = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
          in_valid   <= 1'b1;
          mode       <= cur_op.mode;
          prio_class <= cur_op.prio;
          push_data  <= cur_op.data;
          position   <= cur_op.pos;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        check_result({status_o, read_data_o, read_class_o, total_count_o,
                      high_count_o, medium_count_o, low_count_o});
        results_got++;
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (rx_calm) begin
        stall_now = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          stall_now = 1'b0;
        end else if (roll < 92) begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(0, 2);
        end else begin
          stall_now  = 1'b1;
          stall_left = $urandom_range(5, 30);
        end
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      out_stall <= stall_now || hold_rx;
    end
  end

  // long output hold-off so the block backs up and stalls its input
  initial begin
    @(posedge clk_i);
    while (ops_sent < HoldStart) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldLen) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $realtime, IdleLimit);
    $display("three_level_priority_fifo_unit test failed");
    $finish;
  end

  initial begin
    build_directed();
    build_random();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    $display("Ran %0d operations, checked %0d results, %0d mismatches.",
             ops_sent, results_got, err_count);
    $display("Status mix: ok %0d, bad priority %0d, empty %0d, bad index %0d, full %0d.",
             status_hits[tlpf_pkg::StOk], status_hits[tlpf_pkg::StBadPrio],
             status_hits[tlpf_pkg::StEmpty], status_hits[tlpf_pkg::StBadIndex],
             status_hits[tlpf_pkg::StFull]);
    if (err_count == 0) begin
      $display("three_level_priority_fifo_unit test passed");
    end else begin
      $display("three_level_priority_fifo_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tlpf_pkg.sv
rtl/tlpf_ctrl.sv
rtl/tlpf_datapath.sv
rtl/three_level_priority_fifo_unit.sv
rtl/tlpf_checker.sv
dv/three_level_priority_fifo_unit_tb.sv
